FILE: hdl/pfd_pkg.sv
package pfd_pkg;

  // default panel geometry
  localparam int unsigned PANEL_WIDTH_DEF  = 128;
  localparam int unsigned PANEL_HEIGHT_DEF = 32;

  // rows in one page, and bytes in one output word
  localparam int unsigned PAGE_ROWS  = 8;
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned WORD_W     = 64;

  // coordinate width, wide enough for an 8-bit origin plus an 8-bit extent
  localparam int unsigned COORD_W = 9;

  // a byte with every row set
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  // item kinds
  localparam logic [2:0] KIND_PIXEL   = 3'd0;
  localparam logic [2:0] KIND_FILL    = 3'd1;
  localparam logic [2:0] KIND_OUTLINE = 3'd2;
  localparam logic [2:0] KIND_CLEAR   = 3'd3;
  localparam logic [2:0] KIND_FLUSH   = 3'd4;

  // drawing or flush command
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] w;
    logic [7:0] h;
    logic       on;
  } in_item_t;

  // one data word of a flush
  typedef struct packed {
    logic [1:0]  page;
    logic [6:0]  column;
    logic [63:0] data;
    logic        first_of_page;
    logic        has_data;
    logic        last;
    logic [2:0]  pages_written;
  } out_item_t;

endpackage

FILE: hdl/pfd_if.sv
interface pfd_in_if;
  import pfd_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface pfd_out_if;
  import pfd_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: hdl/page_framebuffer_dirty_flush.sv
// Monochrome page framebuffer with a shadow copy of the panel and dirty-page flush.
// in_i  : drawing commands (pixel, fill, outline, clear) and flush; a transfer
//         happens when valid and ready are high at a clock edge. ready is high
//         only while the sequencer is idle.
// out_o : flush words, one transfer per eight-byte word of a dirty page, with
//         last on the final word; a flush with no dirty page gives one word with
//         has_data low and last high.
// Each pixel, fill or outline command walks the framebuffer words its box touches;
// an outline does this for each of its edge boxes in turn, and a box that falls
// off the panel is skipped. A flush first runs a compare sweep over every word,
// then sends each word of every dirty page in order, or the empty word.
// The frame memory has a single read/modify/write path: each 64-bit word is read,
// then written or checked, before the next word is taken.
// Reset clears all control state; per-word valid bits make the frame read as
// all zeros and the shadow as all ones right away, so there is no clearing pass.
// When the receiver stalls, the word waits in the output register and the
// sequencer holds until it is taken; once the last word is registered the
// block takes new commands again.
module page_framebuffer_dirty_flush #(
  parameter int unsigned PANEL_WIDTH  = pfd_pkg::PANEL_WIDTH_DEF,
  parameter int unsigned PANEL_HEIGHT = pfd_pkg::PANEL_HEIGHT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfd_in_if.sink    in_i,
  pfd_out_if.source out_o
);
  import pfd_pkg::*;

  // geometry
  localparam int unsigned NPAGES = (PANEL_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int unsigned NWORDS = (PANEL_WIDTH + WORD_BYTES - 1) / WORD_BYTES;
  localparam int unsigned PW     = NPAGES > 1 ? $clog2(NPAGES) : 1;
  localparam int unsigned KW     = NWORDS > 1 ? $clog2(NWORDS) : 1;
  localparam int unsigned AW     = PW + KW;
  localparam int unsigned DEPTH  = 1 << AW;
  localparam int unsigned NPSLOT = 1 << PW;

  localparam logic [PW-1:0]      LAST_PG = PW'(NPAGES - 1);
  localparam logic [KW-1:0]      LAST_K  = KW'(NWORDS - 1);
  localparam logic [COORD_W-1:0] W_C     = COORD_W'(PANEL_WIDTH);
  localparam logic [COORD_W-1:0] H_C     = COORD_W'(PANEL_HEIGHT);

  // sequencer states
  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SETUP   = 4'd1;
  localparam logic [3:0] ST_DRAW_RD = 4'd2;
  localparam logic [3:0] ST_DRAW_WR = 4'd3;
  localparam logic [3:0] ST_CMP_RD  = 4'd4;
  localparam logic [3:0] ST_CMP_CHK = 4'd5;
  localparam logic [3:0] ST_SEL     = 4'd6;
  localparam logic [3:0] ST_SND_RD  = 4'd7;
  localparam logic [3:0] ST_SND_WR  = 4'd8;
  localparam logic [3:0] ST_EMPTY   = 4'd9;

  logic [3:0]         state_q, state_d;
  in_item_t           item_q, item_d;
  logic [1:0]         bi_q, bi_d;
  logic [COORD_W-1:0] bx_q, bx_d, by_q, by_d, ex_q, ex_d, ey_q, ey_d;
  logic [KW-1:0]      kstart_q, kstart_d, kend_q, kend_d, k_q, k_d;
  logic [PW-1:0]      pgend_q, pgend_d, pg_q, pg_d;
  logic [NPSLOT-1:0]  dirty_q, dirty_d;
  logic [DEPTH-1:0]   fvalid_q, fvalid_d, svalid_q, svalid_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;

  logic [AW-1:0]       addr;
  logic                f_we, f_re, s_we, s_re;
  logic [WORD_W-1:0]   f_wdata, f_rdata, s_rdata;
  logic [WORD_W-1:0]   fr_word, sh_word, col_mask, draw_mask, new_word, send_word;
  logic                differs, later_dirty, in_xfer, out_free, out_load;
  logic [COORD_W-1:0]  sx, sy, sex, sey, sex_c, sey_c, ew, eh, ex_m1, ey_m1;
  logic                box_empty;

  assign addr    = {pg_q, k_q};
  assign in_xfer = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE);

  // memories hold 64-bit words: eight columns of one page per entry
  pfd_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_frame_ram (
    .clk_i     (clk_i),
    .wr_en_i   (f_we),
    .wr_addr_i (addr),
    .wr_data_i (f_wdata),
    .rd_en_i   (f_re),
    .rd_addr_i (addr),
    .rd_data_o (f_rdata)
  );

  pfd_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_shown_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s_we),
    .wr_addr_i (addr),
    .wr_data_i (send_word),
    .rd_en_i   (s_re),
    .rd_addr_i (addr),
    .rd_data_o (s_rdata)
  );

  // words never written read as their reset contents
  assign fr_word = fvalid_q[addr] ? f_rdata : '0;
  assign sh_word = svalid_q[addr] ? s_rdata : {WORD_BYTES{BYTE_ONES}};

  // byte lanes inside the panel, and pixel mask of the current box
  always_comb begin
    logic [COORD_W-1:0] col, row;
    col_mask  = '0;
    draw_mask = '0;
    for (int b = 0; b < WORD_BYTES; b++) begin
      col = COORD_W'({k_q, 3'(b)});
      col_mask[b*8 +: 8] = (col < W_C) ? BYTE_ONES : 8'h00;
      for (int n = 0; n < PAGE_ROWS; n++) begin
        row = COORD_W'({pg_q, 3'(n)});
        draw_mask[b*8 + n] = (col >= bx_q) && (col < ex_q) && (row >= by_q) && (row < ey_q);
      end
    end
  end

  assign new_word  = item_q.on ? (fr_word | draw_mask) : (fr_word & ~draw_mask);
  assign f_wdata   = new_word;
  assign send_word = fr_word & col_mask;
  assign differs   = ((fr_word ^ sh_word) & col_mask) != '0;

  // any dirty page after the current one
  always_comb begin
    later_dirty = 1'b0;
    for (int i = 0; i < NPSLOT; i++) begin
      if (PW'(i) > pg_q && dirty_q[i]) begin
        later_dirty = 1'b1;
      end
    end
  end

  // bounds of the current box; an outline is four one-pixel-thick boxes
  always_comb begin
    ew = (item_q.kind == KIND_PIXEL) ? COORD_W'(1) : COORD_W'(item_q.w);
    eh = (item_q.kind == KIND_PIXEL) ? COORD_W'(1) : COORD_W'(item_q.h);
    sx  = COORD_W'(item_q.x);
    sy  = COORD_W'(item_q.y);
    sex = sx + ew;
    sey = sy + eh;
    if (item_q.kind == KIND_OUTLINE) begin
      unique case (bi_q)
        2'd0: sey = sy + COORD_W'(1);
        2'd1: sy  = sey - COORD_W'(1);
        2'd2: sex = sx + COORD_W'(1);
        2'd3: sx  = sex - COORD_W'(1);
        default: sx = sx;
      endcase
    end
    sex_c     = (sex > W_C) ? W_C : sex;
    sey_c     = (sey > H_C) ? H_C : sey;
    box_empty = (sx >= sex_c) || (sy >= sey_c);
    ex_m1     = sex_c - COORD_W'(1);
    ey_m1     = sey_c - COORD_W'(1);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    bi_d        = bi_q;
    bx_d        = bx_q;
    by_d        = by_q;
    ex_d        = ex_q;
    ey_d        = ey_q;
    kstart_d    = kstart_q;
    kend_d      = kend_q;
    pgend_d     = pgend_q;
    pg_d        = pg_q;
    k_d         = k_q;
    dirty_d     = dirty_q;
    fvalid_d    = fvalid_q;
    svalid_d    = svalid_q;
    f_we        = 1'b0;
    f_re        = 1'b0;
    s_we        = 1'b0;
    s_re        = 1'b0;
    out_load    = 1'b0;
    out_item_d  = out_item_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          item_d = in_i.item;
          bi_d   = 2'd0;
          unique case (in_i.item.kind)
            KIND_PIXEL, KIND_FILL: state_d = ST_SETUP;
            KIND_OUTLINE: begin
              if (in_i.item.w != 8'd0 && in_i.item.h != 8'd0) begin
                state_d = ST_SETUP;
              end
            end
            KIND_CLEAR: fvalid_d = '0;
            KIND_FLUSH: begin
              pg_d    = '0;
              k_d     = '0;
              dirty_d = '0;
              state_d = ST_CMP_RD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_SETUP: begin
        if (box_empty) begin
          if (item_q.kind == KIND_OUTLINE && bi_q != 2'd3) begin
            bi_d = bi_q + 2'd1;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          bx_d     = sx;
          by_d     = sy;
          ex_d     = sex_c;
          ey_d     = sey_c;
          kstart_d = sx[KW+2:3];
          kend_d   = ex_m1[KW+2:3];
          pgend_d  = ey_m1[PW+2:3];
          k_d      = sx[KW+2:3];
          pg_d     = sy[PW+2:3];
          state_d  = ST_DRAW_RD;
        end
      end

      ST_DRAW_RD: begin
        f_re    = 1'b1;
        state_d = ST_DRAW_WR;
      end

      // read-modify-write of one frame word
      ST_DRAW_WR: begin
        f_we           = 1'b1;
        fvalid_d[addr] = 1'b1;
        state_d        = ST_DRAW_RD;
        if (k_q == kend_q) begin
          k_d = kstart_q;
          if (pg_q == pgend_q) begin
            if (item_q.kind == KIND_OUTLINE && bi_q != 2'd3) begin
              bi_d    = bi_q + 2'd1;
              state_d = ST_SETUP;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            pg_d = pg_q + PW'(1);
          end
        end else begin
          k_d = k_q + KW'(1);
        end
      end

      ST_CMP_RD: begin
        f_re    = 1'b1;
        s_re    = 1'b1;
        state_d = ST_CMP_CHK;
      end

      // compare sweep marks the dirty pages
      ST_CMP_CHK: begin
        if (differs) begin
          dirty_d[pg_q] = 1'b1;
        end
        state_d = ST_CMP_RD;
        if (k_q == LAST_K) begin
          k_d = '0;
          if (pg_q == LAST_PG) begin
            pg_d    = '0;
            state_d = (dirty_d == '0) ? ST_EMPTY : ST_SEL;
          end else begin
            pg_d = pg_q + PW'(1);
          end
        end else begin
          k_d = k_q + KW'(1);
        end
      end

      ST_SEL: begin
        if (dirty_q[pg_q]) begin
          state_d = ST_SND_RD;
        end else begin
          pg_d = pg_q + PW'(1);
        end
      end

      ST_SND_RD: begin
        f_re    = 1'b1;
        state_d = ST_SND_WR;
      end

      // copy the word into the shadow and hand it to the output register
      ST_SND_WR: begin
        if (out_free) begin
          out_load                 = 1'b1;
          s_we                     = 1'b1;
          svalid_d[addr]           = 1'b1;
          out_item_d.page          = 2'(pg_q);
          out_item_d.column        = 7'({k_q, 3'b000});
          out_item_d.data          = send_word;
          out_item_d.first_of_page = (k_q == '0);
          out_item_d.has_data      = 1'b1;
          out_item_d.last          = (k_q == LAST_K) && !later_dirty;
          out_item_d.pages_written = ((k_q == LAST_K) && !later_dirty)
                                     ? 3'($countones(dirty_q)) : 3'd0;
          state_d = ST_SND_RD;
          if (k_q == LAST_K) begin
            k_d = '0;
            if (later_dirty) begin
              pg_d    = pg_q + PW'(1);
              state_d = ST_SEL;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end

      ST_EMPTY: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_item_d = '0;
          out_item_d.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bi_q        <= '0;
      pg_q        <= '0;
      k_q         <= '0;
      dirty_q     <= '0;
      fvalid_q    <= '0;
      svalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bi_q        <= bi_d;
      pg_q        <= pg_d;
      k_q         <= k_d;
      dirty_q     <= dirty_d;
      fvalid_q    <= fvalid_d;
      svalid_q    <= svalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and box registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    bx_q       <= bx_d;
    by_q       <= by_d;
    ex_q       <= ex_d;
    ey_q       <= ey_d;
    kstart_q   <= kstart_d;
    kend_q     <= kend_d;
    pgend_q    <= pgend_d;
    out_item_q <= out_item_d;
  end

  // the empty word only ever closes a flush
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.item.has_data |-> out_o.item.last)
    else $error("empty flush word without last");

  // page count appears on the last word and is nonzero for a data flush
  a_count_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.item.pages_written != 3'd0 |-> out_o.item.last)
    else $error("page count on a word that is not last");

  a_data_last_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.item.has_data && out_o.item.last
    |-> out_o.item.pages_written != 3'd0)
    else $error("last data word carries no page count");

  // a page window opens at column zero
  a_first_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.item.first_of_page |-> out_o.item.column == 7'd0)
    else $error("first word of a page not at column zero");

  // a flush holds off further commands
  a_flush_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready && in_i.item.kind == KIND_FLUSH |=> !in_i.ready)
    else $error("command accepted during a flush");

endmodule

FILE: hdl/pfd_ram.sv
module pfd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                        wr_data_i,
  input  logic                                    rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                        rd_data_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

FILE: tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfd_pkg::*;

  localparam int unsigned PANEL_W = PANEL_WIDTH_DEF;
  localparam int unsigned PANEL_H = PANEL_HEIGHT_DEF;
  localparam int unsigned N_PAGES = (PANEL_H + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int unsigned N_WORDS = (PANEL_W + WORD_BYTES - 1) / WORD_BYTES;
  localparam int unsigned N_BYTES = PANEL_W * N_PAGES;

  // kinds the block ignores
  localparam logic [2:0] KIND_RSVD_5 = 3'd5;
  localparam logic [2:0] KIND_RSVD_6 = 3'd6;
  localparam logic [2:0] KIND_RSVD_7 = 3'd7;

  localparam int unsigned RAND_CMDS   = 183;
  localparam int unsigned IDLE_PCT    = 11;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 600;
  localparam int unsigned DRAIN_LIMIT = 200000;
  localparam int unsigned MAX_PRINTS  = 100;
  localparam int unsigned NUM_DIR     = 26;

  // per-command note: a flush whose words are typed in rather than predicted
  typedef struct {
    bit          typed;
    int unsigned pages;
    logic [7:0]  fill;
  } cmd_note_t;

  typedef struct {
    in_item_t  cmd;
    cmd_note_t note;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm        = 1'b0;
  bit   pressure_on = 1'b0;

  pfd_in_if  in_bus ();
  pfd_out_if out_bus ();

  page_framebuffer_dirty_flush DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // predicted frame and panel contents
  logic [7:0] frame_px [N_BYTES];
  logic [7:0] shown_px [N_BYTES];

  out_item_t   flush_words [$];
  cmd_note_t   cmd_notes [$];
  int unsigned err_count = 0;
  dir_row_t    dir_rows [NUM_DIR];

  always #2 clk_i = ~clk_i;

  // reset once at start
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_error(input string msg);
    if (err_count < MAX_PRINTS) begin
      $display("ERROR %0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // frame drawing
  function automatic void plot_px(input int unsigned px, input int unsigned py, input bit on);
    int unsigned idx;
    logic [7:0]  mask;
    if (px >= PANEL_W || py >= PANEL_H) return;
    idx  = (py / PAGE_ROWS) * PANEL_W + px;
    mask = 8'd1 << (py % PAGE_ROWS);
    if (on) frame_px[idx] = frame_px[idx] | mask;
    else frame_px[idx] = frame_px[idx] & ~mask;
  endfunction

  function automatic void fill_box(input int unsigned x, input int unsigned y,
                                   input int unsigned w, input int unsigned h, input bit on);
    int unsigned x_end;
    int unsigned y_end;
    x_end = x + w;
    y_end = y + h;
    if (x_end > PANEL_W) x_end = PANEL_W;
    if (y_end > PANEL_H) y_end = PANEL_H;
    for (int unsigned py = y; py < y_end; py++) begin
      for (int unsigned px = x; px < x_end; px++) plot_px(px, py, on);
    end
  endfunction

  function automatic void outline_box(input int unsigned x, input int unsigned y,
                                      input int unsigned w, input int unsigned h, input bit on);
    if (w == 0 || h == 0) return;
    for (int unsigned i = 0; i < w && x + i < PANEL_W; i++) begin
      plot_px(x + i, y, on);
      plot_px(x + i, y + h - 1, on);
    end
    for (int unsigned i = 0; i < h && y + i < PANEL_H; i++) begin
      plot_px(x, y + i, on);
      plot_px(x + w - 1, y + i, on);
    end
  endfunction

  // compare pages with the panel copy, queue the words of dirty pages
  function automatic void flush_pages();
    bit          dirty [N_PAGES];
    int unsigned n_dirty;
    int unsigned col;
    out_item_t   r;
    n_dirty = 0;
    for (int unsigned p = 0; p < N_PAGES; p++) begin
      dirty[p] = 1'b0;
      for (int unsigned c = 0; c < PANEL_W; c++) begin
        if (frame_px[p * PANEL_W + c] != shown_px[p * PANEL_W + c]) dirty[p] = 1'b1;
      end
      if (dirty[p]) begin
        for (int unsigned c = 0; c < PANEL_W; c++) begin
          shown_px[p * PANEL_W + c] = frame_px[p * PANEL_W + c];
        end
        n_dirty++;
      end
    end
    if (n_dirty == 0) begin
      r      = '0;
      r.last = 1'b1;
      flush_words.push_back(r);
      return;
    end
    for (int unsigned p = 0; p < N_PAGES; p++) begin
      if (dirty[p]) begin
        for (int unsigned k = 0; k < N_WORDS; k++) begin
          r        = '0;
          r.page   = 2'(p);
          r.column = 7'(k * WORD_BYTES);
          for (int unsigned b = 0; b < WORD_BYTES; b++) begin
            col = k * WORD_BYTES + b;
            if (col < PANEL_W) r.data[8 * b +: 8] = shown_px[p * PANEL_W + col];
          end
          r.first_of_page = (k == 0);
          r.has_data      = 1'b1;
          flush_words.push_back(r);
        end
      end
    end
    flush_words[flush_words.size() - 1].last          = 1'b1;
    flush_words[flush_words.size() - 1].pages_written = 3'(n_dirty);
  endfunction

  // apply one accepted command to the predicted state
  function automatic void render_cmd(input in_item_t c);
    case (c.kind)
      KIND_PIXEL: begin
        plot_px(c.x, c.y, c.on);
      end
      KIND_FILL: begin
        fill_box(c.x, c.y, c.w, c.h, c.on);
      end
      KIND_OUTLINE: begin
        outline_box(c.x, c.y, c.w, c.h, c.on);
      end
      KIND_CLEAR: begin
        foreach (frame_px[i]) frame_px[i] = 8'h00;
      end
      KIND_FLUSH: begin
        flush_pages();
      end
      default: begin
      end
    endcase
  endfunction

  // flush where the first pages all hold one byte value
  function automatic void push_uniform_flush(input int unsigned pages, input logic [7:0] fill);
    out_item_t r;
    if (pages == 0) begin
      r      = '0;
      r.last = 1'b1;
      flush_words.push_back(r);
      return;
    end
    for (int unsigned p = 0; p < pages; p++) begin
      for (int unsigned k = 0; k < N_WORDS; k++) begin
        r               = '0;
        r.page          = 2'(p);
        r.column        = 7'(k * WORD_BYTES);
        r.data          = {WORD_BYTES{fill}};
        r.first_of_page = (k == 0);
        r.has_data      = 1'b1;
        flush_words.push_back(r);
      end
    end
    flush_words[flush_words.size() - 1].last          = 1'b1;
    flush_words[flush_words.size() - 1].pages_written = 3'(pages);
  endfunction

  // table helpers
  function automatic dir_row_t drw(input logic [2:0] kind, input logic [7:0] x,
                                   input logic [7:0] y, input logic [7:0] w,
                                   input logic [7:0] h, input logic on);
    dir_row_t r;
    r.cmd.kind   = kind;
    r.cmd.x      = x;
    r.cmd.y      = y;
    r.cmd.w      = w;
    r.cmd.h      = h;
    r.cmd.on     = on;
    r.note.typed = 1'b0;
    r.note.pages = 0;
    r.note.fill  = 8'h00;
    return r;
  endfunction

  function automatic dir_row_t typed_flush(input int unsigned pages, input logic [7:0] fill);
    dir_row_t r;
    r            = drw(KIND_FLUSH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    r.note.typed = 1'b1;
    r.note.pages = pages;
    r.note.fill  = fill;
    return r;
  endfunction

  // random fields, mostly near the panel
  function automatic logic [7:0] rand_coord(input int unsigned span);
    if ($urandom_range(0, 99) < 85) return 8'($urandom_range(0, span + 3));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_extent();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 8'($urandom_range(0, 12));
    if (roll < 90) return 8'($urandom_range(0, 48));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t    c;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) c.kind = KIND_PIXEL;
    else if (roll < 50) c.kind = KIND_FILL;
    else if (roll < 70) c.kind = KIND_OUTLINE;
    else if (roll < 74) c.kind = KIND_CLEAR;
    else if (roll < 92) c.kind = KIND_FLUSH;
    else begin
      case ($urandom_range(0, 2))
        0: c.kind = KIND_RSVD_5;
        1: c.kind = KIND_RSVD_6;
        default: c.kind = KIND_RSVD_7;
      endcase
    end
    c.x  = rand_coord(PANEL_W);
    c.y  = rand_coord(PANEL_H);
    c.w  = rand_extent();
    c.h  = rand_extent();
    c.on = ($urandom_range(0, 99) < 70);
    return c;
  endfunction

  // offer one command and wait for its transfer
  task automatic send_cmd(input in_item_t c, input cmd_note_t note);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_notes.push_back(note);
    in_bus.item  <= c;
    in_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  // receiver side: random stalls, one long hold-off
  initial begin : rx_side
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pressure_on && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // predict on each command transfer, check each word transfer
  always @(posedge clk_i) begin : scoreboard
    cmd_note_t   note;
    int unsigned n_before;
    out_item_t   exp_w;
    out_item_t   got_w;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        note     = cmd_notes.pop_front();
        n_before = flush_words.size();
        render_cmd(in_bus.item);
        if (note.typed) begin
          while (flush_words.size() > n_before) void'(flush_words.pop_back());
          push_uniform_flush(note.pages, note.fill);
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        got_w = out_bus.item;
        if (flush_words.size() == 0) begin
          flag_error($sformatf("word with nothing expected: page %0d column %0d",
                               got_w.page, got_w.column));
        end else begin
          exp_w = flush_words.pop_front();
          if (got_w.page !== exp_w.page)
            flag_error($sformatf("page got %0d want %0d", got_w.page, exp_w.page));
          if (got_w.column !== exp_w.column)
            flag_error($sformatf("column got %0d want %0d", got_w.column, exp_w.column));
          if (got_w.data !== exp_w.data)
            flag_error($sformatf("data got %h want %h (page %0d column %0d)",
                                 got_w.data, exp_w.data, exp_w.page, exp_w.column));
          if (got_w.first_of_page !== exp_w.first_of_page)
            flag_error($sformatf("first_of_page got %b want %b",
                                 got_w.first_of_page, exp_w.first_of_page));
          if (got_w.has_data !== exp_w.has_data)
            flag_error($sformatf("has_data got %b want %b", got_w.has_data, exp_w.has_data));
          if (got_w.last !== exp_w.last)
            flag_error($sformatf("last got %b want %b", got_w.last, exp_w.last));
          if (got_w.pages_written !== exp_w.pages_written)
            flag_error($sformatf("pages_written got %0d want %0d",
                                 got_w.pages_written, exp_w.pages_written));
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    in_item_t    c;
    cmd_note_t   plain;
    int unsigned counted;
    int unsigned waited;
    in_bus.valid <= 1'b0;
    in_bus.item  <= '0;
    foreach (frame_px[i]) frame_px[i] = 8'h00;
    foreach (shown_px[i]) shown_px[i] = BYTE_ONES;
    plain.typed = 1'b0;
    plain.pages = 0;
    plain.fill  = 8'h00;

    dir_rows = '{
      // blank frame against an all-ones panel: every page goes out as zeros
      typed_flush(N_PAGES, 8'h00),
      // nothing changed since: one empty word
      typed_flush(0, 8'h00),
      drw(KIND_PIXEL,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1),
      drw(KIND_PIXEL,   8'd127, 8'd31,  8'd0,   8'd0,   1'b1),
      drw(KIND_PIXEL,   8'd128, 8'd0,   8'd0,   8'd0,   1'b1),
      drw(KIND_PIXEL,   8'd0,   8'd32,  8'd0,   8'd0,   1'b1),
      drw(KIND_PIXEL,   8'd255, 8'd255, 8'd255, 8'd255, 1'b1),
      drw(KIND_FLUSH,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0),
      drw(KIND_PIXEL,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0),
      // far origin with full extent must not wrap back into the panel
      drw(KIND_FILL,    8'd250, 8'd250, 8'd255, 8'd255, 1'b1),
      drw(KIND_FILL,    8'd120, 8'd28,  8'd255, 8'd255, 1'b1),
      drw(KIND_FILL,    8'd10,  8'd5,   8'd0,   8'd9,   1'b1),
      drw(KIND_FILL,    8'd10,  8'd5,   8'd9,   8'd0,   1'b1),
      // zero-size outlines draw nothing
      drw(KIND_OUTLINE, 8'd20,  8'd3,   8'd0,   8'd7,   1'b1),
      drw(KIND_OUTLINE, 8'd20,  8'd3,   8'd7,   8'd0,   1'b1),
      drw(KIND_OUTLINE, 8'd30,  8'd6,   8'd1,   8'd1,   1'b1),
      drw(KIND_OUTLINE, 8'd40,  8'd2,   8'd30,  8'd20,  1'b1),
      drw(KIND_OUTLINE, 8'd100, 8'd20,  8'd255, 8'd255, 1'b1),
      drw(KIND_RSVD_5,  8'd255, 8'd255, 8'd255, 8'd255, 1'b1),
      drw(KIND_RSVD_6,  8'd0,   8'd0,   8'd10,  8'd10,  1'b1),
      drw(KIND_RSVD_7,  8'd5,   8'd5,   8'd255, 8'd255, 1'b0),
      drw(KIND_FLUSH,   8'd255, 8'd255, 8'd255, 8'd255, 1'b1),
      drw(KIND_FILL,    8'd0,   8'd0,   8'd255, 8'd255, 1'b1),
      typed_flush(N_PAGES, 8'hFF),
      drw(KIND_CLEAR,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0),
      typed_flush(N_PAGES, 8'h00)
    };

    @(posedge rst_ni);
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NUM_DIR; i++) send_cmd(dir_rows[i].cmd, dir_rows[i].note);

    // random commands, one long output hold-off near the start
    pressure_on <= 1'b1;
    counted = 0;
    while (counted < RAND_CMDS) begin
      calm <= (counted >= 60 && counted < 110);
      c = random_cmd();
      send_cmd(c, plain);
      counted++;
    end

    // closing flush so the last drawing is checked
    c      = '0;
    c.kind = KIND_FLUSH;
    send_cmd(c, plain);
    in_bus.valid <= 1'b0;
    calm         <= 1'b0;
    @(posedge clk_i);

    waited = 0;
    while (flush_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (flush_words.size() != 0) begin
      flag_error($sformatf("%0d expected words never arrived", flush_words.size()));
    end

    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
